[design/tpb_pkg.sv]
// Package for the timestamp playout buffer.
// Holds the command codes and the layout of one stored entry; no dependencies.
package tpb_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_POLL   = 2'd2;

  localparam logic [15:0] DELAY_RESET = 16'd500;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] arrival;
    logic        video;
    logic [15:0] nominal;
  } entry_t;

endpackage

[design/timestamp_playout_buffer.sv]
// Timestamp playout buffer: entry store scanned one entry per cycle by a sequencer.
// Tick, full-store insert and empty-store poll stay idle; an insert scans every entry, and a
// poll scans, evaluates and, on a release, waits out any output stall and refills the slot.
// in_tready stays low while an insert or poll is in progress.
// Reset (rst_n low, synchronous) empties the store, clears clock, anchors and stream history,
// and sets the playout delay to 500 ms; entry contents are not cleared.
module timestamp_playout_buffer #(
  parameter int DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // decode_stamp[31:0], nominal_interval[47:32]
  input  logic [2:0]    in_tuser,   // kind[1:0], is_video[2]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // released_stamp[31:0], released_nominal[47:32],
                                    // measured_interval[79:48], hold_time[111:80]
  output logic [0:0]    out_tuser,  // released_video[0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EVAL0, S_EVAL1, S_EVAL2, S_EMIT, S_MOVE_RD, S_MOVE_WR
  } state_t;

  state_t state_r;

  tpb_pkg::entry_t mem [DEPTH];
  tpb_pkg::entry_t rd_data_r;
  tpb_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            mem_we;

  logic [31:0] clock_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] cmp_idx_r;
  logic          cmp_valid_r;
  logic          cmp_first_r;
  logic          dup_r;
  logic          op_poll_r;
  logic [15:0]   delay_r;
  logic [31:0]   anchor_stamp_r;
  logic [31:0]   anchor_time_r;
  logic [31:0]   last_audio_r;
  logic [31:0]   last_video_r;
  logic [31:0]   diff_r;
  logic [31:0]   sum_r;

  tpb_pkg::entry_t pend_r;
  tpb_pkg::entry_t best_r;
  logic [AW-1:0]   best_idx_r;

  logic          out_tvalid_r;
  logic [111:0]  out_tdata_r;
  logic [0:0]    out_tuser_r;

  logic          issue;
  logic          in_beat;
  logic [1:0]    in_kind;
  logic          anchor_zero;
  logic [31:0]   last_sel;
  logic [31:0]   gap;
  logic          emit;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign in_kind    = in_tuser[1:0];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign issue       = (state_r == S_SCAN) && (idx_r < count_r);
  assign anchor_zero = (anchor_stamp_r == 32'd0) && (anchor_time_r == 32'd0);
  assign last_sel    = best_r.video ? last_video_r : last_audio_r;
  assign gap         = (last_sel == 32'd0) ? 32'd0 : best_r.arrival - last_sel;
  assign emit        = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_comb begin
    rd_addr = idx_r[AW-1:0];
    if (state_r == S_MOVE_RD) begin
      rd_addr = count_r[AW-1:0];
    end
    mem_we  = 1'b0;
    wr_addr = best_idx_r;
    wr_data = rd_data_r;
    if (state_r == S_MOVE_WR) begin
      mem_we = 1'b1;
    end else if (state_r == S_SCAN && !op_poll_r && !issue && !cmp_valid_r && !dup_r) begin
      mem_we  = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      clock_r        <= 32'd0;
      count_r        <= '0;
      idx_r          <= '0;
      cmp_valid_r    <= 1'b0;
      dup_r          <= 1'b0;
      op_poll_r      <= 1'b0;
      delay_r        <= tpb_pkg::DELAY_RESET;
      anchor_stamp_r <= 32'd0;
      anchor_time_r  <= 32'd0;
      last_audio_r   <= 32'd0;
      last_video_r   <= 32'd0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delay_r <= cfg_data;
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      cmp_valid_r <= issue;
      cmp_first_r <= (idx_r == '0);
      cmp_idx_r   <= idx_r[AW-1:0];

      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            pend_r.stamp   <= in_tdata[31:0];
            pend_r.arrival <= clock_r;
            pend_r.video   <= in_tuser[2];
            pend_r.nominal <= in_tdata[47:32];
            idx_r          <= '0;
            dup_r          <= 1'b0;
            case (in_kind)
              tpb_pkg::KIND_INSERT: begin
                op_poll_r <= 1'b0;
                if (count_r < CW'(DEPTH)) begin
                  state_r <= S_SCAN;
                end
              end
              tpb_pkg::KIND_TICK: clock_r <= clock_r + 32'd1;
              tpb_pkg::KIND_POLL: begin
                op_poll_r <= 1'b1;
                if (count_r != '0) begin
                  state_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (cmp_valid_r) begin
            if (op_poll_r) begin
              if (cmp_first_r || (rd_data_r.stamp < best_r.stamp)) begin
                best_r     <= rd_data_r;
                best_idx_r <= cmp_idx_r;
              end
            end else if (rd_data_r.stamp == pend_r.stamp) begin
              dup_r <= 1'b1;
            end
          end
          if (issue) begin
            idx_r <= idx_r + CW'(1);
          end else if (!cmp_valid_r) begin
            if (op_poll_r) begin
              state_r <= S_EVAL0;
            end else begin
              if (!dup_r) begin
                count_r <= count_r + CW'(1);
              end
              state_r <= S_IDLE;
            end
          end
        end
        S_EVAL0: begin
          if (anchor_zero) begin
            anchor_stamp_r <= best_r.stamp;
            anchor_time_r  <= clock_r;
            diff_r         <= 32'd0;
          end else begin
            diff_r <= best_r.stamp - anchor_stamp_r;
          end
          state_r <= S_EVAL1;
        end
        S_EVAL1: begin
          sum_r   <= diff_r + anchor_time_r;
          state_r <= S_EVAL2;
        end
        S_EVAL2: begin
          if ((sum_r + {16'd0, delay_r}) < clock_r) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit) begin
            out_tdata_r  <= {clock_r - best_r.arrival, gap, best_r.nominal, best_r.stamp};
            out_tuser_r  <= best_r.video;
            if (best_r.video) begin
              last_video_r <= best_r.arrival;
            end else begin
              last_audio_r <= best_r.arrival;
            end
            count_r <= count_r - CW'(1);
            state_r <= S_MOVE_RD;
          end
        end
        S_MOVE_RD: state_r <= S_MOVE_WR;
        S_MOVE_WR: state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/tpb_checker.sv]
// Port-level checks for the timestamp playout buffer, bound to the top level.
// Depends on tpb_pkg for the command codes.
module tpb_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic [2:0]    in_tuser,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [111:0]  out_tdata,
  input logic          cfg_ready
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("ready dropped without an input beat");

  a_tick_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1:0] == tpb_pkg::KIND_TICK |=> in_tready)
    else $error("tick did not return to idle");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config channel stalled");

endmodule

bind timestamp_playout_buffer tpb_checker u_tpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

[test/timestamp_playout_buffer_tb.sv]
`timescale 1ns / 1ps
// Testbench for timestamp_playout_buffer: streams insert, tick and poll beats through a
// queue-fed driver and checks every released packet against an in-bench playout predictor.
// Depends on tpb_pkg and the timestamp_playout_buffer RTL.
module timestamp_playout_buffer_tb;

  localparam int DEPTH = 32;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TRAFFIC_BEATS = 200;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] stamp;
    logic        video;
    logic [15:0] nominal;
  } beat_t;

  typedef struct {
    logic [31:0] stamp;
    logic        video;
    logic [15:0] nominal;
    logic [31:0] interval;
    logic [31:0] hold;
  } playout_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  timestamp_playout_buffer #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  tpb_pkg::entry_t held [DEPTH];
  int          held_count;
  logic [31:0] media_clock;
  logic [31:0] anchor_stamp;
  logic [31:0] anchor_clock;
  logic [31:0] last_arrival [2];
  logic [15:0] delay_ms;
  playout_t    due_releases [$];

  // stimulus state
  beat_t       pending_beats [$];
  logic [31:0] gen_clock;
  logic [31:0] last_gen_stamp;
  logic [15:0] phase_delay [8];
  bit          no_idle;
  int          hold_req;
  int          hold_seen;
  int          in_gap;
  int          out_hold;

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  int          idle_cycles;
  int          errors;
  int          n_beats;
  int          n_stored;
  int          n_dropped;
  int          n_checked;
  int          n_settings;

  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(150, 30);
  endfunction

  task automatic predict_playout(input beat_t b);
    int i;
    int best;
    logic [31:0] due;
    bit dup;
    playout_t p;
    case (b.kind)
      tpb_pkg::KIND_INSERT: begin
        dup = 1'b0;
        for (i = 0; i < held_count; i++)
          if (held[i].stamp == b.stamp) dup = 1'b1;
        if (dup || held_count >= DEPTH) begin
          n_dropped++;
        end else begin
          held[held_count] = '{stamp: b.stamp, arrival: media_clock, video: b.video,
                               nominal: b.nominal};
          held_count++;
          n_stored++;
        end
      end
      tpb_pkg::KIND_TICK: media_clock = media_clock + 32'd1;
      tpb_pkg::KIND_POLL: begin
        if (held_count > 0) begin
          best = 0;
          for (i = 1; i < held_count; i++)
            if (held[i].stamp < held[best].stamp) best = i;
          if (anchor_stamp == 32'd0 && anchor_clock == 32'd0) begin
            anchor_stamp = held[best].stamp;
            anchor_clock = media_clock;
          end
          due = held[best].stamp - anchor_stamp + anchor_clock + {16'd0, delay_ms};
          if (due < media_clock) begin
            p.stamp = held[best].stamp;
            p.video = held[best].video;
            p.nominal = held[best].nominal;
            p.interval = (last_arrival[p.video] == 32'd0) ? 32'd0 :
                         held[best].arrival - last_arrival[p.video];
            p.hold = media_clock - held[best].arrival;
            last_arrival[p.video] = held[best].arrival;
            due_releases.insert(due_releases.size(), p);
            held_count--;
            held[best] = held[held_count];
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // monitor: output beats are checked before the input beat of the same edge is predicted
  always @(posedge clk) begin
    beat_t b;
    playout_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_releases.size() == 0) begin
          errors++;
          $display("%0t: unexpected release beat, stamp %h", $time, out_tdata[31:0]);
        end else begin
          want = due_releases.pop_front();
          check_field("released_stamp", want.stamp, out_tdata[31:0]);
          check_field("released_video", {31'd0, want.video}, {31'd0, out_tuser[0]});
          check_field("released_nominal", {16'd0, want.nominal}, {16'd0, out_tdata[47:32]});
          check_field("measured_interval", want.interval, out_tdata[79:48]);
          check_field("hold_time", want.hold, out_tdata[111:80]);
          n_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        b.kind = in_tuser[1:0];
        b.video = in_tuser[2];
        b.stamp = in_tdata[31:0];
        b.nominal = in_tdata[47:32];
        predict_playout(b);
        n_beats++;
      end
      if (cfg_valid && cfg_ready) delay_ms = cfg_data;
      in_fire <= in_tvalid && in_tready;
      cfg_fire <= cfg_valid && cfg_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d releases outstanding", $time,
               idle_cycles, due_releases.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_fire)) begin
      if (in_tvalid) in_gap = idle_length();
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        in_tdata <= {b.nominal, b.stamp};
        in_tuser <= {b.video, b.kind};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      out_hold = LONG_HOLD;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_hold = idle_length();
    end
  end

  task automatic queue_beat(input logic [1:0] kind, input logic [31:0] stamp,
                            input logic video, input logic [15:0] nominal);
    beat_t nb;
    nb.kind = kind;
    nb.stamp = stamp;
    nb.video = video;
    nb.nominal = nominal;
    pending_beats.insert(pending_beats.size(), nb);
    if (kind == tpb_pkg::KIND_TICK) gen_clock = gen_clock + 32'd1;
    if (kind == tpb_pkg::KIND_INSERT) last_gen_stamp = stamp;
  endtask

  task automatic queue_filler(input logic [1:0] kind);
    queue_beat(kind, $urandom, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
  endtask

  // mostly stamps that follow the clock, a little late, duplicate, far and spare-kind noise
  task automatic queue_traffic(input int count);
    int n;
    int r;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        case ($urandom_range(3))
          0: queue_filler(KIND_SPARE);
          1: queue_beat(tpb_pkg::KIND_INSERT, $urandom, 1'($urandom_range(1)),
                        16'($urandom_range(16'hFFFF)));
          2: queue_beat(tpb_pkg::KIND_INSERT, last_gen_stamp, 1'($urandom_range(1)),
                        16'($urandom_range(16'hFFFF)));
          default: queue_beat(tpb_pkg::KIND_INSERT, $urandom_range(gen_clock, 0),
                              1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
        endcase
      end else if (r < 48) begin
        queue_filler(tpb_pkg::KIND_TICK);
      end else if (r < 72) begin
        queue_filler(tpb_pkg::KIND_POLL);
      end else begin
        queue_beat(tpb_pkg::KIND_INSERT, gen_clock + $urandom_range(40),
                   1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || !in_tready || due_releases.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_delay(input logic [15:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int i;
    held_count = 0;
    media_clock = '0;
    anchor_stamp = '0;
    anchor_clock = '0;
    last_arrival[0] = '0;
    last_arrival[1] = '0;
    delay_ms = tpb_pkg::DELAY_RESET;
    gen_clock = '0;
    last_gen_stamp = '0;
    phase_delay = '{16'd3, 16'd40, 16'd0, 16'hFFFF, 16'd12, 16'd500, 16'd25, 16'd7};
    phase_delay[6] = 16'($urandom_range(100, 1));
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset delay: empty poll, spare kind, duplicate, anchor latch at zero and relatch
    queue_beat(tpb_pkg::KIND_POLL, '1, 1'b1, '1);
    queue_beat(KIND_SPARE, '1, 1'b1, '1);
    queue_beat(tpb_pkg::KIND_INSERT, 32'd0, 1'b0, 16'hFFFF);
    queue_beat(tpb_pkg::KIND_INSERT, 32'd0, 1'b1, 16'h1234);
    queue_filler(tpb_pkg::KIND_POLL);
    queue_filler(tpb_pkg::KIND_TICK);
    queue_beat(tpb_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1'b1, 16'h0000);
    queue_beat(tpb_pkg::KIND_INSERT, 32'd5, 1'b0, 16'hA5A5);
    queue_filler(tpb_pkg::KIND_POLL);
    queue_filler(tpb_pkg::KIND_TICK);
    queue_filler(tpb_pkg::KIND_TICK);
    wait_drained();

    // zero delay: zero-arrival release, late poll, wrapped due time, empty again
    write_delay(16'd0);
    queue_filler(tpb_pkg::KIND_POLL);
    queue_filler(tpb_pkg::KIND_POLL);
    repeat (4) queue_filler(tpb_pkg::KIND_TICK);
    repeat (3) queue_filler(tpb_pkg::KIND_POLL);
    wait_drained();

    // max delay: overfill the store
    write_delay(16'hFFFF);
    for (i = 0; i < 36; i++) begin
      queue_beat(tpb_pkg::KIND_INSERT, gen_clock + 2 * i, 1'($urandom_range(1)),
                 16'($urandom_range(16'hFFFF)));
      if (i % 6 == 5) queue_filler(tpb_pkg::KIND_POLL);
    end
    wait_drained();

    // drain back-to-back while the receiver holds off
    write_delay(16'd1);
    no_idle = 1'b1;
    hold_req++;
    repeat (90) queue_filler(tpb_pkg::KIND_TICK);
    repeat (40) queue_filler(tpb_pkg::KIND_POLL);
    wait_drained();
    no_idle = 1'b0;

    for (i = 0; i < 8; i++) begin
      write_delay(phase_delay[i]);
      no_idle = (i == 4);
      queue_traffic(TRAFFIC_BEATS);
      wait_drained();
    end
    no_idle = 1'b0;

    $display("Run covered %0d input beats: %0d packets stored, %0d dropped, %0d releases checked.",
             n_beats, n_stored, n_dropped, n_checked);
    $display("Delay written %0d times from 0 to 65535; media clock reached %0d ms.",
             n_settings, media_clock);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
